// ===== hdl/fletcher64_xor_checksum_core_defines.svh =====
// Assertion macros shared by the checksum RTL.
`ifndef FLETCHER64_XOR_CHECKSUM_CORE_DEFINES_SVH
`define FLETCHER64_XOR_CHECKSUM_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FXC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define FXC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/fxc_pkg.sv =====
// Types, constants and the end-around adder for the Fletcher-64 xor checksum.
package fxc_pkg;

   localparam int unsigned WORD_W = 32;
   localparam logic [WORD_W-1:0] SUM_ALL_ONES = '1;
   localparam logic [WORD_W-1:0] WORD_XOR = WORD_W'(1);

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      logic              has_word;
      logic              last_word;
   } item_type;

   typedef struct packed {
      logic [WORD_W-1:0] first_sum;
      logic [WORD_W-1:0] second_sum;
   } sum_pair_type;

   // Ones-complement add; with acc nonzero the result stays in 1..all ones.
   function automatic logic [WORD_W-1:0] eac_add(input logic [WORD_W-1:0] acc,
                                                 input logic [WORD_W-1:0] addend);
      logic [WORD_W:0] raw;
      raw = {1'b0, acc} + {1'b0, addend};
      return raw[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw[WORD_W]};
   endfunction

endpackage

// ===== hdl/fxc_accum.sv =====
// Running first/second sum state with the chained end-around update.
`include "fletcher64_xor_checksum_core_defines.svh"

module fxc_accum import fxc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  item_type     item,
   output sum_pair_type sums
);

   logic [WORD_W-1:0] first_ff, first_in;
   logic [WORD_W-1:0] second_ff, second_in;
   logic [WORD_W-1:0] first_upd, second_upd;

   always_comb begin
      first_upd  = first_ff;
      second_upd = second_ff;
      if (item.has_word) begin
         first_upd  = eac_add(first_ff, item.data_word ^ WORD_XOR);
         second_upd = eac_add(second_ff, first_upd);
      end
      sums.first_sum  = first_upd;
      sums.second_sum = second_upd;
   end

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      if (step) begin
         if (item.last_word) begin
            first_in  = SUM_ALL_ONES;
            second_in = SUM_ALL_ONES;
         end else begin
            first_in  = first_upd;
            second_in = second_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= SUM_ALL_ONES;
         second_ff <= SUM_ALL_ONES;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   `FXC_ASSERT_IMPL(a_state_nonzero, clock, reset, 1'b1, first_ff != '0 && second_ff != '0)
   `FXC_ASSERT_NEXT(a_restart_after_last, clock, reset, step && item.last_word,
                    first_ff == SUM_ALL_ONES && second_ff == SUM_ALL_ONES)

endmodule

// ===== hdl/fletcher64_xor_checksum_core.sv =====
// Top level of the streaming Fletcher-64 checksum over words xored with 1.
// Path: req to input reg, then a last item's sums to result reg and rsp_valid.
// Throughput: one word per cycle unless a last item waits for a full result slot;
// two chained 32-bit end-around adds (input reg to sum/result regs) set the cycle.
// Reset: clears both valids and restarts both sums at 0xFFFFFFFF.
`include "fletcher64_xor_checksum_core_defines.svh"

module fletcher64_xor_checksum_core import fxc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [WORD_W-1:0] req_data_word,
   input  logic              req_has_word,
   input  logic              req_last_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_first_sum,
   output logic [WORD_W-1:0] rsp_second_sum
);

   logic         s1_valid_ff, s1_valid_in;
   item_type     s1_item_ff, s1_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   sum_pair_type rsp_sums_ff, rsp_sums_in;
   sum_pair_type sums;
   logic         advance;

   fxc_accum u_accum (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (s1_item_ff),
      .sums  (sums)
   );

   // A last item needs a free result slot; other items always advance.
   assign advance   = s1_valid_ff && (!s1_item_ff.last_word || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_item_in  = '{data_word: req_data_word, has_word: req_has_word,
                         last_word: req_last_word};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sums_in  = rsp_sums_ff;
      if (advance && s1_item_ff.last_word) begin
         rsp_valid_in = 1'b1;
         rsp_sums_in  = sums;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      rsp_sums_ff <= rsp_sums_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_first_sum  = rsp_sums_ff.first_sum;
   assign rsp_second_sum = rsp_sums_ff.second_sum;

   `FXC_ASSERT_IMPL(a_stall_needs_item, clock, reset, !req_ready, s1_valid_ff)
   `FXC_ASSERT_IMPL(a_rsp_sums_nonzero, clock, reset, rsp_valid_ff,
                    rsp_sums_ff.first_sum != '0 && rsp_sums_ff.second_sum != '0)

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the streaming Fletcher-64 xor checksum core.
module tb_top;
   import fxc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [WORD_W-1:0] req_data_word = '0;
   logic              req_has_word = 1'b0;
   logic              req_last_word = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_first_sum;
   logic [WORD_W-1:0] rsp_second_sum;

   logic [WORD_W-1:0] model_first = SUM_ALL_ONES;
   logic [WORD_W-1:0] model_second = SUM_ALL_ONES;
   sum_pair_type      pending_sums[$];
   int                mismatch_count = 0;
   int                req_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                hold_left = 0;
   int                quiet_cycles = 0;

   fletcher64_xor_checksum_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_word (req_data_word),
      .req_has_word  (req_has_word),
      .req_last_word (req_last_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_first_sum (rsp_first_sum),
      .rsp_second_sum(rsp_second_sum)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ones-complement add modulo 2^32-1
   function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      logic [63:0] s;
      s = {32'd0, a} + {32'd0, b};
      s = {32'd0, s[31:0]} + {32'd0, s[63:32]};
      s = {32'd0, s[31:0]} + {32'd0, s[63:32]};
      return s[WORD_W-1:0];
   endfunction

   function automatic void fold_word(input logic [WORD_W-1:0] word, input logic has,
                                     input logic last);
      sum_pair_type pair;
      if (model_first == '0) model_first = SUM_ALL_ONES;
      if (model_second == '0) model_second = SUM_ALL_ONES;
      if (has) begin
         model_first = ones_add(model_first, word ^ WORD_W'(1));
         model_second = ones_add(model_second, model_first);
      end
      if (last) begin
         pair.first_sum = model_first;
         pair.second_sum = model_second;
         pending_sums.push_back(pair);
         model_first = SUM_ALL_ONES;
         model_second = SUM_ALL_ONES;
      end
   endfunction

   task automatic send_item(input logic [WORD_W-1:0] word, input logic has,
                            input logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         req_data_word <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_word <= word;
      req_has_word <= has;
      req_last_word <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fold_word(word, has, last);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'hFFFF_FFFE;
         3: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // one message of random length; sometimes closed by a bare close item
   task automatic send_message(inout int sent);
      int  len;
      bit  bare;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 6);
      bare = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item($urandom, 1'b0, 1'b0);
            sent++;
         end
         send_item(pick_word(), 1'b1, !bare && (i == len - 1));
         sent++;
      end
      if (bare) begin
         send_item($urandom, 1'b0, 1'b1);
         sent++;
      end
   endtask

   task automatic test_directed();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item('0, 1'b0, 1'b1);
      send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_item('0, 1'b1, 1'b1);
      send_item(32'h0000_0001, 1'b1, 1'b1);
      send_item(32'hFFFF_FFFE, 1'b1, 1'b1);
      send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(32'hA5A5_5A5A, 1'b0, 1'b0);
      send_item(32'h1234_5678, 1'b1, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_item(32'h8765_4321, 1'b1, 1'b0);
      send_item('0, 1'b0, 1'b1);
      for (int i = 0; i < 8; i++) send_item(32'hFFFF_FFFF, 1'b1, i == 7);
      send_item(32'hFFFF_FFFE, 1'b1, 1'b0);
      send_item(32'hFFFF_FFFE, 1'b1, 1'b0);
      send_item(32'h5555_5555, 1'b1, 1'b0);
      send_item(32'hAAAA_AAAA, 1'b1, 1'b1);
   endtask

   task automatic test_random(input int idle_pct, input int stall_pct, input int count);
      int sent;
      sent = 0;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (sent < count) send_message(sent);
   endtask

   // receiver held off while every transaction closes a message
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left = 200;
      for (int i = 0; i < 40; i++) send_item(pick_word(), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      sum_pair_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_sums.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected transaction: first %h second %h",
                           rsp_first_sum, rsp_second_sum);
            end else begin
               want = pending_sums.pop_front();
               if (rsp_first_sum !== want.first_sum ||
                   rsp_second_sum !== want.second_sum) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("sum mismatch: first exp %h got %h, second exp %h got %h",
                              want.first_sum, rsp_first_sum,
                              want.second_sum, rsp_second_sum);
               end
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("fletcher64_xor_checksum_core: mismatch");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(0, 0, 330);
      test_random(49, 0, 330);
      test_random(0, 49, 330);
      test_random(16, 16, 330);
      test_backpressure();
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_sums.size() == 0) begin
         $display("fletcher64_xor_checksum_core: match");
      end else begin
         $display("fletcher64_xor_checksum_core: mismatch");
      end
      $finish;
   end

endmodule
